// ===== rtl/core/ileb_pkg.sv =====
// Shared types, constants and microprogram for the integer literal encoder.
package ileb_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned PC_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OPC_U14 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_SHL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_OR  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_NEG = 8'd3;

    localparam logic [7:0] RST_OPC_U14 = 8'd1;
    localparam logic [7:0] RST_OPC_SHL = 8'd2;
    localparam logic [7:0] RST_OPC_OR  = 8'd3;
    localparam logic [7:0] RST_OPC_NEG = 8'd4;

    localparam logic [7:0] PUSH_FLAG = 8'h80;

    typedef enum logic [1:0] {
        SEL_CHUNK,
        SEL_CONST,
        SEL_OPC
    } t_sel;

    typedef enum logic [1:0] {
        OP_U14,
        OP_SHL,
        OP_OR,
        OP_NEG
    } t_op;

    typedef struct packed {
        t_sel       sel;
        logic [6:0] arg;
        logic       stop;
    } t_uword;

    // entry points
    localparam logic [PC_W-1:0] ENT_U7  = 5'd0;
    localparam logic [PC_W-1:0] ENT_U14 = 5'd1;
    localparam logic [PC_W-1:0] ENT_U21 = 5'd4;
    localparam logic [PC_W-1:0] ENT_U32 = 5'd13;
    localparam logic [PC_W-1:0] ENT_NEG = 5'd30;

    function automatic t_uword mk(input t_sel sel, input logic [6:0] arg, input logic stop);
        t_uword w;
        w.sel  = sel;
        w.arg  = arg;
        w.stop = stop;
        return w;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = mk(SEL_CHUNK, 7'd0, 1'b1);
            5'd1:    w = mk(SEL_CHUNK, 7'd1, 1'b0);
            5'd2:    w = mk(SEL_CHUNK, 7'd0, 1'b0);
            5'd3:    w = mk(SEL_OPC, 7'(OP_U14), 1'b1);
            5'd4:    w = mk(SEL_CHUNK, 7'd0, 1'b0);
            5'd5:    w = mk(SEL_CHUNK, 7'd1, 1'b0);
            5'd6:    w = mk(SEL_CONST, 7'd7, 1'b0);
            5'd7:    w = mk(SEL_OPC, 7'(OP_SHL), 1'b0);
            5'd8:    w = mk(SEL_CHUNK, 7'd2, 1'b0);
            5'd9:    w = mk(SEL_CONST, 7'd14, 1'b0);
            5'd10:   w = mk(SEL_OPC, 7'(OP_SHL), 1'b0);
            5'd11:   w = mk(SEL_OPC, 7'(OP_OR), 1'b0);
            5'd12:   w = mk(SEL_OPC, 7'(OP_OR), 1'b1);
            5'd13:   w = mk(SEL_CHUNK, 7'd0, 1'b0);
            5'd14:   w = mk(SEL_CHUNK, 7'd1, 1'b0);
            5'd15:   w = mk(SEL_CONST, 7'd7, 1'b0);
            5'd16:   w = mk(SEL_OPC, 7'(OP_SHL), 1'b0);
            5'd17:   w = mk(SEL_OPC, 7'(OP_OR), 1'b0);
            5'd18:   w = mk(SEL_CHUNK, 7'd2, 1'b0);
            5'd19:   w = mk(SEL_CONST, 7'd14, 1'b0);
            5'd20:   w = mk(SEL_OPC, 7'(OP_SHL), 1'b0);
            5'd21:   w = mk(SEL_OPC, 7'(OP_OR), 1'b0);
            5'd22:   w = mk(SEL_CHUNK, 7'd3, 1'b0);
            5'd23:   w = mk(SEL_CONST, 7'd21, 1'b0);
            5'd24:   w = mk(SEL_OPC, 7'(OP_SHL), 1'b0);
            5'd25:   w = mk(SEL_OPC, 7'(OP_OR), 1'b0);
            5'd26:   w = mk(SEL_CHUNK, 7'd4, 1'b0);
            5'd27:   w = mk(SEL_CONST, 7'd28, 1'b0);
            5'd28:   w = mk(SEL_OPC, 7'(OP_SHL), 1'b0);
            5'd29:   w = mk(SEL_OPC, 7'(OP_OR), 1'b1);
            default: w = mk(SEL_OPC, 7'(OP_NEG), 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/ileb_if.sv =====
// Channel interfaces: literal in, code byte out, configuration write.
interface ileb_lit_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] literal_value;
    modport source (output valid, output literal_value, input ready);
    modport sink (input valid, input literal_value, output ready);
endinterface

interface ileb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

interface ileb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ileb_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                       data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/integer_literal_bytecode_encoder_unit.sv =====
// Integer literal bytecode encoder: microcoded byte sequencer, top level.
//
// i_lit takes one signed 32-bit literal per word; o_code gives the bytecode
// bytes that rebuild it, one byte per word, last_byte set on the final one.
// i_cfg writes the four opcode registers (index 0..3, other indexes ignored);
// it is always ready and should only be used while the block is idle.
// A literal gives 1, 3, 9 or 17 bytes, plus one negate byte if negative.
// The step counter walks a 31-entry control ROM, one byte per step, and each
// step loads the output register. Accepting a literal loads its entry step;
// the first byte is then registered at the output on the next step, and
// each further step registers one byte while the output is not stalled.
// The next literal is accepted as soon as the last byte has been loaded,
// while that byte may still wait at the output.
// If the receiver stalls, the sequencer holds its step and the output word
// holds. Reset (synchronous, active low) empties the sequencer and output
// register and sets the opcodes to 1, 2, 3 and 4.
module integer_literal_bytecode_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ileb_lit_if.sink    i_lit,
    ileb_byte_if.source o_code,
    ileb_cfg_if.sink    i_cfg
);

    logic [7:0]  r_opc_u14, r_opc_shl, r_opc_or, r_opc_neg;
    logic [31:0] r_mag;
    logic        r_neg;
    logic        r_busy;
    logic [ileb_pkg::PC_W-1:0] r_pc, n_pc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last;

    logic        lit_acc;
    logic [31:0] raw, mag;
    logic [ileb_pkg::PC_W-1:0] entry;
    ileb_pkg::t_uword uw;
    logic        fire;
    logic        seq_end;
    logic [6:0]  chunk;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opc_u14 <= ileb_pkg::RST_OPC_U14;
            r_opc_shl <= ileb_pkg::RST_OPC_SHL;
            r_opc_or  <= ileb_pkg::RST_OPC_OR;
            r_opc_neg <= ileb_pkg::RST_OPC_NEG;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ileb_pkg::CFG_OPC_U14: r_opc_u14 <= i_cfg.data;
                ileb_pkg::CFG_OPC_SHL: r_opc_shl <= i_cfg.data;
                ileb_pkg::CFG_OPC_OR:  r_opc_or  <= i_cfg.data;
                ileb_pkg::CFG_OPC_NEG: r_opc_neg <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_lit.ready = !r_busy;
    assign lit_acc     = i_lit.valid && !r_busy;
    assign raw         = i_lit.literal_value;
    assign mag         = raw[31] ? (32'd0 - raw) : raw;

    always_comb begin
        if (mag[31:21] != '0) begin
            entry = ileb_pkg::ENT_U32;
        end else if (mag[20:14] != '0) begin
            entry = ileb_pkg::ENT_U21;
        end else if (mag[13:7] != '0) begin
            entry = ileb_pkg::ENT_U14;
        end else begin
            entry = ileb_pkg::ENT_U7;
        end
    end

    assign uw      = ileb_pkg::ucode(r_pc);
    assign fire    = r_busy && (!r_out_valid || o_code.ready);
    assign seq_end = uw.stop && (!r_neg || r_pc == ileb_pkg::ENT_NEG);

    always_comb begin
        unique case (uw.arg[2:0])
            3'd0:    chunk = r_mag[6:0];
            3'd1:    chunk = r_mag[13:7];
            3'd2:    chunk = r_mag[20:14];
            3'd3:    chunk = r_mag[27:21];
            3'd4:    chunk = {3'b000, r_mag[31:28]};
            default: chunk = '0;
        endcase
    end

    always_comb begin
        n_out_byte = ileb_pkg::PUSH_FLAG;
        unique case (uw.sel)
            ileb_pkg::SEL_CHUNK: n_out_byte = ileb_pkg::PUSH_FLAG | {1'b0, chunk};
            ileb_pkg::SEL_CONST: n_out_byte = ileb_pkg::PUSH_FLAG | {1'b0, uw.arg};
            ileb_pkg::SEL_OPC: begin
                unique case (ileb_pkg::t_op'(uw.arg[1:0]))
                    ileb_pkg::OP_U14: n_out_byte = r_opc_u14;
                    ileb_pkg::OP_SHL: n_out_byte = r_opc_shl;
                    ileb_pkg::OP_OR:  n_out_byte = r_opc_or;
                    ileb_pkg::OP_NEG: n_out_byte = r_opc_neg;
                    default:          n_out_byte = r_opc_neg;
                endcase
            end
            default: n_out_byte = ileb_pkg::PUSH_FLAG;
        endcase
    end

    always_comb begin
        if (uw.stop && r_neg && r_pc != ileb_pkg::ENT_NEG) begin
            n_pc = ileb_pkg::ENT_NEG;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ileb_pkg::ENT_U7;
        end else if (lit_acc) begin
            r_busy <= 1'b1;
            r_pc   <= entry;
        end else if (fire) begin
            r_pc <= n_pc;
            if (seq_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lit_acc) begin
            r_mag <= mag;
            r_neg <= raw[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= n_out_byte;
            r_out_last <= seq_end;
        end
    end

    assign o_code.valid     = r_out_valid;
    assign o_code.code_byte = r_out_byte;
    assign o_code.last_byte = r_out_last;

`ifndef SYNTHESIS
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lit_acc |=> r_busy && !i_lit.ready)
        else $error("sequencer not started after literal accepted");

    a_neg_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_pc == ileb_pkg::ENT_NEG |-> r_neg)
        else $error("negate step reached for a non-negative literal");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && seq_end |=> !r_busy && r_out_valid && r_out_last)
        else $error("final byte did not close the sequence");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_out_valid && !o_code.ready |=> $stable(r_pc))
        else $error("step advanced while output stalled");
`endif

endmodule

// ===== sim/integer_literal_bytecode_encoder_unit_test.sv =====
// Self-checking bench for the integer literal bytecode encoder: directed table, then random.
module integer_literal_bytecode_encoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_code;

    // n_typed = 0: checked against the predictor; otherwise the first byte sits at the top
    typedef struct packed {
        logic [31:0]  lit;
        logic [4:0]   n_typed;
        logic [143:0] bytes;
    } t_row;

    localparam int NDIR = 22;
    localparam t_row DIRECTED [NDIR] = '{
        '{32'sd0,           5'd1,  144'h80},
        '{32'sd1,           5'd0,  144'h0},
        '{32'sd127,         5'd1,  144'hFF},
        '{-32'sd1,          5'd2,  144'h8104},
        '{-32'sd127,        5'd0,  144'h0},
        '{32'sd128,         5'd3,  144'h818001},
        '{-32'sd128,        5'd4,  144'h81800104},
        '{32'sd16383,       5'd3,  144'hFFFF01},
        '{-32'sd16383,      5'd0,  144'h0},
        '{32'sd16384,       5'd9,  144'h80808702818E020303},
        '{-32'sd16384,      5'd0,  144'h0},
        '{32'sd2097151,     5'd0,  144'h0},
        '{-32'sd2097151,    5'd0,  144'h0},
        '{32'sd2097152,     5'd0,  144'h0},
        '{-32'sd2097152,    5'd0,  144'h0},
        '{32'h7FFF_FFFF,    5'd0,  144'h0},
        '{32'h8000_0001,    5'd0,  144'h0},
        '{32'h8000_0000,    5'd18, 144'h8080870203808E020380950203889C020304},
        '{32'h5555_5555,    5'd0,  144'h0},
        '{32'hAAAA_AAAA,    5'd0,  144'h0},
        '{32'h1234_5678,    5'd0,  144'h0},
        '{-32'sd100,        5'd0,  144'h0}
    };

    localparam logic [31:0] BOUNDARY_MAGS [8] = '{
        32'd0, 32'd127, 32'd128, 32'd16383, 32'd16384, 32'd2097151, 32'd2097152,
        32'h7FFF_FFFF
    };

    logic clk = 1'b0;
    logic rst_n;

    ileb_lit_if  lit_ch ();
    ileb_byte_if code_ch ();
    ileb_cfg_if  cfg_ch ();

    integer_literal_bytecode_encoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_lit   (lit_ch),
        .o_code  (code_ch),
        .i_cfg   (cfg_ch)
    );

    logic [7:0] opc_u14 = ileb_pkg::RST_OPC_U14;
    logic [7:0] opc_shl = ileb_pkg::RST_OPC_SHL;
    logic [7:0] opc_or  = ileb_pkg::RST_OPC_OR;
    logic [7:0] opc_neg = ileb_pkg::RST_OPC_NEG;

    t_code        code_pending [$];
    logic [4:0]   typed_n;
    logic [143:0] typed_bytes;
    int           lits_offered = 0;
    int           lits_taken   = 0;
    int           mismatches   = 0;
    int           src_gap_max  = 3;
    int           sink_stall_max = 3;
    bit           hold_req     = 1'b0;
    t_code        want;
    t_code        got;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void predict_code(input logic [31:0] raw);
        logic [31:0] mag;
        logic [31:0] chunk;
        logic [7:0]  seq [18];
        int          n;
        mag = raw[31] ? 32'd0 - raw : raw;
        if (mag < 32'd128) begin
            seq[0] = {1'b1, mag[6:0]};
            n = 1;
        end else if (mag < 32'd16384) begin
            seq[0] = {1'b1, mag[13:7]};
            seq[1] = {1'b1, mag[6:0]};
            seq[2] = opc_u14;
            n = 3;
        end else if (mag < 32'd2097152) begin
            seq[0] = {1'b1, mag[6:0]};
            seq[1] = {1'b1, mag[13:7]};
            seq[2] = {1'b1, 7'd7};
            seq[3] = opc_shl;
            seq[4] = {1'b1, mag[20:14]};
            seq[5] = {1'b1, 7'd14};
            seq[6] = opc_shl;
            seq[7] = opc_or;
            seq[8] = opc_or;
            n = 9;
        end else begin
            seq[0] = {1'b1, mag[6:0]};
            n = 1;
            for (int k = 7; k <= 28; k += 7) begin
                chunk = mag >> k;
                seq[n]     = {1'b1, chunk[6:0]};
                seq[n + 1] = {1'b1, 7'(k)};
                seq[n + 2] = opc_shl;
                seq[n + 3] = opc_or;
                n = n + 4;
            end
        end
        if (raw[31]) begin
            seq[n] = opc_neg;
            n = n + 1;
        end
        for (int i = 0; i < n; i++)
            code_pending.push_back(t_code'{code: seq[i], last: (i == n - 1)});
    endfunction

    // scoreboard: expectations go in on literal acceptance, words are checked on the way out
    always @(posedge clk) begin
        if (rst_n) begin
            if (lit_ch.valid && lit_ch.ready) begin
                lits_taken++;
                if (typed_n != 5'd0) begin
                    for (int i = 0; i < int'(typed_n); i++)
                        code_pending.push_back(t_code'{
                            code: typed_bytes[(int'(typed_n) - 1 - i) * 8 +: 8],
                            last: (i == int'(typed_n) - 1)});
                end else begin
                    predict_code(lit_ch.literal_value);
                end
            end
            if (code_ch.valid && code_ch.ready) begin
                got = t_code'{code: code_ch.code_byte, last: code_ch.last_byte};
                if (code_pending.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h last %b",
                             $time, got.code, got.last);
                    mismatches++;
                end else begin
                    want = code_pending.pop_front();
                    if (got.code !== want.code) begin
                        $display("%0t: code_byte expected %h, got %h",
                                 $time, want.code, got.code);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_byte expected %b, got %b",
                                 $time, want.last, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        int stall;
        code_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (hold_req) begin
                stall = 300;
                hold_req = 1'b0;
            end
            if (stall != 0) begin
                code_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            code_ch.ready <= 1'b1;
            do @(posedge clk); while (!code_ch.valid);
        end
    end

    task automatic send_literal(input logic [31:0] v, input logic [4:0] n,
                                input logic [143:0] bytes);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            lit_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        lit_ch.valid         <= 1'b1;
        lit_ch.literal_value <= v;
        typed_n              <= n;
        typed_bytes          <= bytes;
        lits_offered++;
        do @(posedge clk); while (!lit_ch.ready);
    endtask

    task automatic drain();
        lit_ch.valid <= 1'b0;
        while (lits_taken != lits_offered || code_pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_opcodes(input logic [7:0] v_u14, v_shl, v_or, v_neg,
                               input logic [7:0] stray_idx, stray_val);
        logic [7:0] idx [5];
        logic [7:0] val [5];
        idx = '{stray_idx, ileb_pkg::CFG_OPC_U14, ileb_pkg::CFG_OPC_SHL,
                ileb_pkg::CFG_OPC_OR, ileb_pkg::CFG_OPC_NEG};
        val = '{stray_val, v_u14, v_shl, v_or, v_neg};
        for (int i = 0; i < 5; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (!cfg_ch.ready);
            case (idx[i])
                ileb_pkg::CFG_OPC_U14: opc_u14 = val[i];
                ileb_pkg::CFG_OPC_SHL: opc_shl = val[i];
                ileb_pkg::CFG_OPC_OR:  opc_or  = val[i];
                ileb_pkg::CFG_OPC_NEG: opc_neg = val[i];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] mag;
        logic [31:0] lit;
        rst_n                = 1'b0;
        lit_ch.valid         = 1'b0;
        lit_ch.literal_value = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        typed_n              = '0;
        typed_bytes          = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NDIR; r++)
            send_literal(DIRECTED[r].lit, DIRECTED[r].n_typed, DIRECTED[r].bytes);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_opcodes(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h5A);
                1: set_opcodes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd4, 8'hA5);
                default: set_opcodes(8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom_range(4, 255)),
                                     8'($urandom));
            endcase
            src_gap_max    = (p == 0) ? 0 : (p == 1) ? 3 : $urandom_range(0, 1) * 3;
            sink_stall_max = (p == 0) ? 0 : (p == 1) ? 3 : $urandom_range(0, 1) * 3;
            if (p == 2) begin
                src_gap_max = 0;
                hold_req    = 1'b1;
            end
            for (int j = 0; j < 58; j++) begin
                case ($urandom_range(0, 5))
                    0: mag = $urandom_range(0, 127);
                    1: mag = $urandom_range(128, 16383);
                    2: mag = $urandom_range(16384, 2097151);
                    3: mag = $urandom_range(32'h0020_0000, 32'h7FFF_FFFF);
                    4: mag = BOUNDARY_MAGS[3'($urandom_range(0, 7))];
                    default: mag = $urandom;
                endcase
                lit = $urandom_range(0, 1) ? 32'd0 - mag : mag;
                send_literal(lit, 5'd0, 144'h0);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ileb_pkg.sv
rtl/core/ileb_if.sv
rtl/core/integer_literal_bytecode_encoder_unit.sv
sim/integer_literal_bytecode_encoder_unit_test.sv
